FILE: rtl/cssd_pkg.sv
package cssd_pkg;

    localparam int SECTOR_BYTES = 2352;
    localparam int HEADER_BYTES = 12;

    localparam int POS_W     = 12;
    localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
    localparam int TALLY_W   = 12;
    localparam int THR_W     = 12;
    localparam int MISS_W    = 4;
    localparam int LFSR_W    = 15;

    localparam logic [TALLY_W-1:0] TALLY_MAX  = {TALLY_W{1'b1}};
    localparam logic [LFSR_W-1:0]  LFSR_SEED  = LFSR_W'(1);

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT       = 1'b1;

    localparam logic [THR_W-1:0]  RESET_REJECT_THRESHOLD = 12'd1000;
    localparam logic [MISS_W-1:0] RESET_MISS_LIMIT       = 4'd4;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_CAND   = 2'd1,
        MODE_SYNC   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       error_flag;
        logic       padding_flag;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_error;
        logic             out_padding;
        logic [POS_W-1:0] byte_index;
        logic             last_of_sector;
        logic             sector_rejected;
        logic             header_missed;
    } t_out_item;

    // A queue entry is either one finished data item or a header token that the
    // output stage expands into the whole sync pattern.
    typedef struct packed {
        logic      is_header;
        t_out_item item;
    } t_entry;

    typedef logic [7:0] t_win [HEADER_BYTES];

    function automatic logic [7:0] sync_byte(input logic [HDR_IDX_W-1:0] idx);
        return (idx == '0 || idx == HDR_IDX_W'(HEADER_BYTES - 1)) ? 8'h00 : 8'hFF;
    endfunction

    function automatic logic window_is_sync(input t_win w);
        logic hit;
        hit = 1'b1;
        for (int j = 0; j < HEADER_BYTES; j++) begin
            if (w[j] != sync_byte(HDR_IDX_W'(j))) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // Eight descrambler bits, least significant bit first.
    function automatic logic [7:0] lfsr_key(input logic [LFSR_W-1:0] s);
        logic [7:0]        k;
        logic [LFSR_W-1:0] t;
        t = s;
        for (int j = 0; j < 8; j++) begin
            k[j] = t[0];
            t    = {t[0] ^ t[1], t[LFSR_W-1:1]};
        end
        return k;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_adv(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] t;
        t = s;
        for (int j = 0; j < 8; j++) begin
            t = {t[0] ^ t[1], t[LFSR_W-1:1]};
        end
        return t;
    endfunction

endpackage

FILE: rtl/cdrom_sector_sync_descrambler.sv
// CD-ROM sector sync finder and descrambler.
// Input channel: one raw byte with its error and padding flags per item, valid/ready.
// Output channel: one sector byte per item with its position, end-of-sector, rejected
// and header-missed marks, valid/ready. Configuration: a write-only port for the
// reject threshold (index 0) and the header miss limit (index 1), written while idle.
// Throughput: one input item per cycle sustained while the receiver takes every item.
// Each sector header is collected silently and then played out as twelve sync pattern
// items, one per cycle, so the output runs twelve items behind the input within a
// sector; a 32-entry queue between the sync logic and the output register soaks up
// that lag. A data byte is registered in the push register, written into the queue
// and loaded into the output register; header items follow once the last header byte is in.
// Ready depends on the queue fill and the push register, so a stalled receiver fills
// the queue and then holds the input off; nothing is lost or reordered.
// Reset (synchronous, active low) returns to searching with an all-zero window, an
// empty queue, no output item, and the configuration at its defaults (1000 and 4).
module cdrom_sector_sync_descrambler
    import cssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    logic             accept;
    logic             push;
    t_entry           push_entry;
    logic             pop;
    t_entry           head;
    logic             empty;
    logic [FIFO_AW:0] fill;

    // Room is kept for the item still in the push register.
    assign o_in_ready = (fill + (FIFO_AW+1)'(push)) < (FIFO_AW+1)'(FIFO_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    cssd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_item       (i_in_item),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    cssd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_empty      (empty),
        .o_count      (fill)
    );

    cssd_expand u_expand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule

FILE: rtl/cssd_front.sv
module cssd_front
    import cssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    output logic                  o_push,
    output t_entry                o_push_entry
);

    logic [THR_W-1:0]        r_thr;
    logic [MISS_W-1:0]       r_miss_limit;

    t_mode                   r_mode,      n_mode;
    t_win                    r_win_byte,  n_win_byte;
    logic [HEADER_BYTES-1:0] r_win_err,   n_win_err;
    logic [HEADER_BYTES-1:0] r_win_pad,   n_win_pad;
    logic [POS_W-1:0]        r_pos,       n_pos;
    logic [MISS_W-1:0]       r_miss,      n_miss;
    logic [TALLY_W-1:0]      r_err_tally, n_err_tally;
    logic [TALLY_W-1:0]      r_pad_tally, n_pad_tally;
    logic [LFSR_W-1:0]       r_lfsr,      n_lfsr;
    logic                    r_push,      n_push;
    t_entry                  r_push_entry, n_push_entry;

    logic                    pos_last;
    logic [TALLY_W-1:0]      err_sat;
    logic [TALLY_W-1:0]      pad_sat;
    logic [MISS_W:0]         miss_inc;
    logic [HDR_IDX_W-1:0]    hidx;
    logic                    rej;
    t_entry                  data_entry;
    t_entry                  hdr_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= RESET_REJECT_THRESHOLD;
            r_miss_limit <= RESET_MISS_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REJECT_THRESHOLD: r_thr        <= THR_W'(i_cfg_data);
                CFG_MISS_LIMIT:       r_miss_limit <= i_cfg_data[MISS_W-1:0];
                default: ;
            endcase
        end
    end

    assign pos_last = (r_pos >= POS_W'(SECTOR_BYTES - 1));
    assign err_sat  = (r_err_tally == TALLY_MAX) ? r_err_tally
                                                 : r_err_tally + TALLY_W'(i_item.error_flag);
    assign pad_sat  = (r_pad_tally == TALLY_MAX) ? r_pad_tally
                                                 : r_pad_tally + TALLY_W'(i_item.padding_flag);
    assign miss_inc = {1'b0, r_miss} + (MISS_W+1)'(1);
    assign hidx     = r_pos[HDR_IDX_W-1:0];
    assign rej      = (err_sat > r_thr) || (pad_sat > r_thr);

    always_comb begin
        data_entry                     = '0;
        data_entry.item.out_byte       = i_item.data_byte ^ lfsr_key(r_lfsr);
        data_entry.item.out_error      = i_item.error_flag;
        data_entry.item.out_padding    = i_item.padding_flag;
        data_entry.item.byte_index     = r_pos;
        data_entry.item.last_of_sector = pos_last;
        hdr_entry                      = '0;
        hdr_entry.is_header            = 1'b1;
    end

    always_comb begin
        n_mode       = r_mode;
        n_win_byte   = r_win_byte;
        n_win_err    = r_win_err;
        n_win_pad    = r_win_pad;
        n_pos        = r_pos;
        n_miss       = r_miss;
        n_err_tally  = r_err_tally;
        n_pad_tally  = r_pad_tally;
        n_lfsr       = r_lfsr;
        n_push       = 1'b0;
        n_push_entry = r_push_entry;

        if (i_accept) begin
            unique case (r_mode)
                MODE_CAND: begin
                    n_push       = 1'b1;
                    n_push_entry = data_entry;
                    n_lfsr       = lfsr_adv(r_lfsr);
                    n_err_tally  = err_sat;
                    n_pad_tally  = pad_sat;
                    n_pos        = pos_last ? '0 : r_pos + POS_W'(1);
                    if (pos_last) begin
                        n_push_entry.item.sector_rejected = rej;
                        if (rej) begin
                            n_mode = MODE_SEARCH;
                            for (int j = 0; j < HEADER_BYTES; j++) begin
                                n_win_byte[j] = 8'h00;
                            end
                            n_win_err = '0;
                            n_win_pad = '0;
                        end else begin
                            n_mode = MODE_SYNC;
                            n_miss = '0;
                        end
                    end
                end
                MODE_SYNC: begin
                    if (r_pos < POS_W'(HEADER_BYTES)) begin
                        // Header bytes are gathered silently and checked on the last one.
                        n_win_byte[hidx] = i_item.data_byte;
                        n_win_err[hidx]  = i_item.error_flag;
                        n_win_pad[hidx]  = i_item.padding_flag;
                        if (r_pos == '0) begin
                            n_err_tally = '0;
                            n_pad_tally = '0;
                        end
                        if (r_pos < POS_W'(HEADER_BYTES - 1)) begin
                            n_pos = r_pos + POS_W'(1);
                        end else if (window_is_sync(n_win_byte)) begin
                            n_miss       = '0;
                            n_pos        = POS_W'(HEADER_BYTES);
                            n_lfsr       = LFSR_SEED;
                            n_push       = 1'b1;
                            n_push_entry = hdr_entry;
                        end else if (miss_inc > {1'b0, r_miss_limit}) begin
                            // The collected header stays behind as the search window.
                            n_miss = '0;
                            n_mode = MODE_SEARCH;
                            n_pos  = '0;
                        end else begin
                            n_miss       = miss_inc[MISS_W-1:0];
                            n_pos        = POS_W'(HEADER_BYTES);
                            n_lfsr       = LFSR_SEED;
                            n_push       = 1'b1;
                            n_push_entry = hdr_entry;
                            n_push_entry.item.header_missed = 1'b1;
                        end
                    end else begin
                        n_push       = 1'b1;
                        n_push_entry = data_entry;
                        n_push_entry.item.header_missed = (r_miss != '0);
                        n_lfsr       = lfsr_adv(r_lfsr);
                        n_pos        = pos_last ? '0 : r_pos + POS_W'(1);
                    end
                end
                default: begin
                    n_mode = MODE_SEARCH;
                    for (int j = 0; j < HEADER_BYTES - 1; j++) begin
                        n_win_byte[j] = r_win_byte[j+1];
                    end
                    n_win_byte[HEADER_BYTES-1] = i_item.data_byte;
                    n_win_err = {i_item.error_flag, r_win_err[HEADER_BYTES-1:1]};
                    n_win_pad = {i_item.padding_flag, r_win_pad[HEADER_BYTES-1:1]};
                    if (window_is_sync(n_win_byte)) begin
                        n_err_tally  = TALLY_W'($countones(n_win_err));
                        n_pad_tally  = TALLY_W'($countones(n_win_pad));
                        n_mode       = MODE_CAND;
                        n_pos        = POS_W'(HEADER_BYTES);
                        n_lfsr       = LFSR_SEED;
                        n_push       = 1'b1;
                        n_push_entry = hdr_entry;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SEARCH;
            for (int j = 0; j < HEADER_BYTES; j++) begin
                r_win_byte[j] <= 8'h00;
            end
            r_win_err   <= '0;
            r_win_pad   <= '0;
            r_pos       <= '0;
            r_miss      <= '0;
            r_err_tally <= '0;
            r_pad_tally <= '0;
            r_lfsr      <= LFSR_SEED;
            r_push      <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_win_byte  <= n_win_byte;
            r_win_err   <= n_win_err;
            r_win_pad   <= n_win_pad;
            r_pos       <= n_pos;
            r_miss      <= n_miss;
            r_err_tally <= n_err_tally;
            r_pad_tally <= n_pad_tally;
            r_lfsr      <= n_lfsr;
            r_push      <= n_push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_push_entry <= n_push_entry;
    end

    assign o_push       = r_push;
    assign o_push_entry = r_push_entry;

endmodule

FILE: rtl/cssd_fifo.sv
module cssd_fifo
    import cssd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_entry             i_push_entry,
    input  logic               i_pop,
    output t_entry             o_head,
    output logic               o_empty,
    output logic [FIFO_AW:0]   o_count
);

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(do_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

FILE: rtl/cssd_expand.sv
module cssd_expand
    import cssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  logic      i_empty,
    output logic      o_pop,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [HDR_IDX_W-1:0] r_hcnt, n_hcnt;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item, n_out_item;
    logic                 load;
    logic                 take;
    logic                 hdr_done;

    assign load     = !r_out_valid || i_out_ready;
    assign take     = load && !i_empty;
    assign hdr_done = (r_hcnt == HDR_IDX_W'(HEADER_BYTES - 1));

    always_comb begin
        n_hcnt      = r_hcnt;
        n_out_item  = r_out_item;
        n_out_valid = load ? 1'b0 : r_out_valid;
        o_pop       = 1'b0;
        if (take) begin
            n_out_valid = 1'b1;
            if (i_head.is_header) begin
                // One header token yields the clean sync pattern, one byte a cycle while the output is not stalled.
                n_out_item               = '0;
                n_out_item.out_byte      = sync_byte(r_hcnt);
                n_out_item.byte_index    = POS_W'(r_hcnt);
                n_out_item.header_missed = i_head.item.header_missed;
                o_pop                    = hdr_done;
                n_hcnt                   = hdr_done ? '0 : r_hcnt + HDR_IDX_W'(1);
            end else begin
                n_out_item = i_head.item;
                o_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hcnt      <= n_hcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/cssd_checker.sv
module cssd_checker
    import cssd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.last_of_sector == (o_out_item.byte_index == POS_W'(SECTOR_BYTES - 1))))
        else $error("end-of-sector mark does not match the byte position");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.sector_rejected |->
            o_out_item.last_of_sector && !o_out_item.header_missed)
        else $error("rejected mark outside the last byte of a candidate sector");

    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.byte_index < POS_W'(HEADER_BYTES)) |->
            !o_out_item.out_error && !o_out_item.out_padding &&
            (o_out_item.out_byte == sync_byte(o_out_item.byte_index[HDR_IDX_W-1:0])))
        else $error("header item is not the clean sync pattern");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind cdrom_sector_sync_descrambler cssd_checker u_cssd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

FILE: dv/tb_cdrom_sector_sync_descrambler.sv
`timescale 1ns / 100ps

// Tracks the sync state of the byte stream and holds the sector bytes that the block
// still owes on its output.
class sector_scoreboard;
    logic [cssd_pkg::THR_W-1:0]   thr;
    logic [cssd_pkg::MISS_W-1:0]  lim;
    cssd_pkg::t_mode              mode;
    logic [7:0]                   win_byte [cssd_pkg::HEADER_BYTES];
    logic                         win_err  [cssd_pkg::HEADER_BYTES];
    logic                         win_pad  [cssd_pkg::HEADER_BYTES];
    int unsigned                  pos;
    logic [cssd_pkg::MISS_W-1:0]  misses;
    logic [cssd_pkg::TALLY_W-1:0] err_tally;
    logic [cssd_pkg::TALLY_W-1:0] pad_tally;
    logic [cssd_pkg::LFSR_W-1:0]  lfsr;
    cssd_pkg::t_out_item          bytes_due [$];
    int                           mismatches;
    int                           checked;

    function new();
        thr = cssd_pkg::RESET_REJECT_THRESHOLD;
        lim = cssd_pkg::RESET_MISS_LIMIT;
        mode = cssd_pkg::MODE_SEARCH;
        clear_window();
        pos = 0;
        misses = '0;
        err_tally = '0;
        pad_tally = '0;
        lfsr = cssd_pkg::LFSR_SEED;
        mismatches = 0;
        checked = 0;
    endfunction

    function void clear_window();
        for (int i = 0; i < cssd_pkg::HEADER_BYTES; i++) begin
            win_byte[i] = 8'h00;
            win_err[i] = 1'b0;
            win_pad[i] = 1'b0;
        end
    endfunction

    function void set_reg(input logic [cssd_pkg::CFG_IDX_W-1:0] idx,
                          input logic [cssd_pkg::CFG_DATA_W-1:0] data);
        if (idx == cssd_pkg::CFG_REJECT_THRESHOLD) begin
            thr = data[cssd_pkg::THR_W-1:0];
        end else if (idx == cssd_pkg::CFG_MISS_LIMIT) begin
            lim = data[cssd_pkg::MISS_W-1:0];
        end
    endfunction

    function logic [7:0] pattern_byte(input int i);
        return (i == 0 || i == cssd_pkg::HEADER_BYTES - 1) ? 8'h00 : 8'hFF;
    endfunction

    function bit header_clean();
        for (int i = 0; i < cssd_pkg::HEADER_BYTES; i++) begin
            if (win_byte[i] != pattern_byte(i)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // A header always comes out as the clean pattern, and the descrambler restarts.
    function void queue_header(input logic missed);
        cssd_pkg::t_out_item r;
        for (int i = 0; i < cssd_pkg::HEADER_BYTES; i++) begin
            r = '0;
            r.out_byte = pattern_byte(i);
            r.byte_index = i[cssd_pkg::POS_W-1:0];
            r.header_missed = missed;
            bytes_due.push_back(r);
        end
        lfsr = cssd_pkg::LFSR_SEED;
    endfunction

    // Eight steps of x^15+x+1, output bits taken least significant first.
    function logic [7:0] next_key();
        logic [7:0] key;
        logic       fb;
        for (int k = 0; k < 8; k++) begin
            key[k] = lfsr[0];
            fb = lfsr[0] ^ lfsr[1];
            lfsr = (lfsr >> 1) | ({{(cssd_pkg::LFSR_W-1){1'b0}}, fb} << 14);
        end
        return key;
    endfunction

    function int pending();
        return bytes_due.size();
    endfunction

    function void absorb_byte(input cssd_pkg::t_in_item it);
        cssd_pkg::t_out_item r;
        logic [cssd_pkg::MISS_W:0] n;
        logic                      last;
        logic                      rej;
        r = '0;
        if (mode != cssd_pkg::MODE_CAND && mode != cssd_pkg::MODE_SYNC) begin
            mode = cssd_pkg::MODE_SEARCH;
            for (int i = 0; i < cssd_pkg::HEADER_BYTES - 1; i++) begin
                win_byte[i] = win_byte[i+1];
                win_err[i] = win_err[i+1];
                win_pad[i] = win_pad[i+1];
            end
            win_byte[cssd_pkg::HEADER_BYTES-1] = it.data_byte;
            win_err[cssd_pkg::HEADER_BYTES-1] = it.error_flag;
            win_pad[cssd_pkg::HEADER_BYTES-1] = it.padding_flag;
            if (!header_clean()) begin
                return;
            end
            err_tally = '0;
            pad_tally = '0;
            for (int i = 0; i < cssd_pkg::HEADER_BYTES; i++) begin
                err_tally += win_err[i];
                pad_tally += win_pad[i];
            end
            mode = cssd_pkg::MODE_CAND;
            pos = cssd_pkg::HEADER_BYTES;
            queue_header(1'b0);
            return;
        end

        if (mode == cssd_pkg::MODE_SYNC && pos < cssd_pkg::HEADER_BYTES) begin
            win_byte[pos] = it.data_byte;
            win_err[pos] = it.error_flag;
            win_pad[pos] = it.padding_flag;
            if (pos == 0) begin
                err_tally = '0;
                pad_tally = '0;
            end
            if (pos < cssd_pkg::HEADER_BYTES - 1) begin
                pos++;
                return;
            end
            if (header_clean()) begin
                misses = '0;
            end else begin
                n = {1'b0, misses} + 1'b1;
                if (n > {1'b0, lim}) begin
                    // Sync is lost; the collected header stays as the search window.
                    misses = '0;
                    mode = cssd_pkg::MODE_SEARCH;
                    pos = 0;
                    return;
                end
                misses = n[cssd_pkg::MISS_W-1:0];
            end
            pos = cssd_pkg::HEADER_BYTES;
            queue_header(misses != '0);
            return;
        end

        last = (pos >= cssd_pkg::SECTOR_BYTES - 1);
        rej = 1'b0;
        r.out_byte = it.data_byte ^ next_key();
        if (mode == cssd_pkg::MODE_CAND) begin
            if (it.error_flag && err_tally != cssd_pkg::TALLY_MAX) begin
                err_tally++;
            end
            if (it.padding_flag && pad_tally != cssd_pkg::TALLY_MAX) begin
                pad_tally++;
            end
            if (last) begin
                rej = (err_tally > thr) || (pad_tally > thr);
                if (rej) begin
                    mode = cssd_pkg::MODE_SEARCH;
                    clear_window();
                end else begin
                    mode = cssd_pkg::MODE_SYNC;
                    misses = '0;
                end
            end
        end else begin
            r.header_missed = (misses != '0);
        end
        r.out_error = it.error_flag;
        r.out_padding = it.padding_flag;
        r.byte_index = pos[cssd_pkg::POS_W-1:0];
        r.last_of_sector = last;
        r.sector_rejected = rej;
        bytes_due.push_back(r);
        pos = last ? 0 : pos + 1;
    endfunction

    task flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH: %s", what);
    endtask

    task check_out_byte(input cssd_pkg::t_out_item got);
        cssd_pkg::t_out_item exp;
        checked++;
        if (bytes_due.size() == 0) begin
            flag_mismatch($sformatf("output item %0d arrived with nothing expected", checked));
            return;
        end
        exp = bytes_due.pop_front();
        if (got !== exp) begin
            flag_mismatch($sformatf({"output item %0d: got %h e%b p%b idx %0d l%b r%b m%b,",
                " exp %h e%b p%b idx %0d l%b r%b m%b"}, checked,
                got.out_byte, got.out_error, got.out_padding, got.byte_index,
                got.last_of_sector, got.sector_rejected, got.header_missed,
                exp.out_byte, exp.out_error, exp.out_padding, exp.byte_index,
                exp.last_of_sector, exp.sector_rejected, exp.header_missed));
        end
    endtask
endclass

module tb_cdrom_sector_sync_descrambler;
    import cssd_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 200000;

    typedef enum int {
        HDR_CLEAN,
        HDR_BITFLIP,
        HDR_SHIFTED
    } t_hdr_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    sector_scoreboard sb = new();

    bit tx_busy = 1'b0;
    bit rx_busy = 1'b0;
    bit hold_req = 1'b0;
    bit in_offered = 1'b0;

    cdrom_sector_sync_descrambler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_draw(input bit busy);
        if (busy) begin
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
    endfunction

    function automatic logic rand_flag(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic e, input logic p);
        t_in_item it;
        int       gap;
        it.data_byte = b;
        it.error_flag = e;
        it.padding_flag = p;
        gap = idle_draw(tx_busy);
        if (gap > 0) begin
            if (in_offered) begin
                i_in_valid <= 1'b0;
                in_offered = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        in_offered = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.absorb_byte(it);
    endtask

    task automatic stop_input();
        if (in_offered) begin
            i_in_valid <= 1'b0;
            in_offered = 1'b0;
        end
    endtask

    task automatic send_header(input t_hdr_kind kind, input int flag_pct);
        logic [7:0] hb [HEADER_BYTES];
        int         j;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            hb[i] = sb.pattern_byte(i);
        end
        case (kind)
            HDR_BITFLIP: begin
                j = $urandom_range(0, HEADER_BYTES - 1);
                hb[j] = hb[j] ^ (8'd1 << $urandom_range(0, 7));
            end
            // One byte late: a single trailing zero byte completes a sync in the window.
            HDR_SHIFTED: begin
                hb[0] = 8'($urandom_range(0, 255));
                for (int i = 1; i < HEADER_BYTES; i++) begin
                    hb[i] = sb.pattern_byte(i - 1);
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < HEADER_BYTES; i++) begin
            send_byte(hb[i], rand_flag(flag_pct), rand_flag(flag_pct));
        end
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, rand_flag(50), rand_flag(50));
        end
    endtask

    task automatic drain();
        for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) begin
            @(posedge i_clk);
        end
    endtask

    // Configuration is only touched once the block has nothing left in flight.
    task automatic quiesce();
        stop_input();
        drain();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    initial begin : receiver
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = idle_draw(rx_busy);
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_out_byte(o_out_item);
        end
    end

    initial begin : stimulus
        logic [7:0] junk;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_REJECT_THRESHOLD, 12'd1000);
        write_reg(CFG_MISS_LIMIT, 12'd2);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // A near miss: the last byte of the pattern is wrong.
        for (int i = 0; i < HEADER_BYTES - 1; i++) begin
            send_byte(sb.pattern_byte(i), 1'b0, 1'b0);
        end
        send_byte(8'h80, 1'b0, 1'b0);
        send_header(HDR_BITFLIP, 10);
        send_noise(10);
        // The trailing zero byte completes the sync and opens a candidate sector.
        send_header(HDR_SHIFTED, 10);
        send_byte(8'h00, 1'b1, 1'b1);
        send_noise(80);
        // A sync pattern inside an open sector is plain data.
        send_header(HDR_CLEAN, 0);

        quiesce();
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_REJECT_THRESHOLD, 12'd2352);
        write_reg(CFG_MISS_LIMIT, {junk, 4'd15});

        // The receiver holds off while the sender streams without gaps.
        tx_busy = 1'b1;
        hold_req = 1'b1;
        send_noise(150);
        tx_busy = 1'b0;
        rx_busy = 1'b1;
        send_noise(90);
        rx_busy = 1'b0;
        send_noise(80);

        stop_input();
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.flag_mismatch($sformatf("%0d sector bytes never came out", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
